// ----- design/sfns_pkg.sv -----
// ----------------------------------------------------------------------------
// sfns_pkg: shared types and constants for the focus neighbour selector
// Direction indexes, register indexes, action codes, level codes and the working width of the
// coordinate arithmetic.
// ----------------------------------------------------------------------------
package sfns_pkg;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned SIZE_W  = 15;
	localparam int unsigned GAP_W   = 16;
	localparam int unsigned ID_W    = 16;
	localparam int unsigned CALC_W  = 20;
	localparam int unsigned NUM_DIR = 4;

	typedef logic [2:0]        level_t;
	typedef logic [GAP_W-1:0]  gap_t;
	typedef logic signed [CALC_W-1:0] calc_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_TIE     = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_ORIGIN_W = 2'd2,
		REG_ORIGIN_H = 2'd3
	} reg_index_t;

	localparam logic [1:0] DIR_TOP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT  = 2'd1;
	localparam logic [1:0] DIR_LEFT   = 2'd2;
	localparam logic [1:0] DIR_BOTTOM = 2'd3;

	localparam level_t LEVEL_SPAN  = 3'd1;
	localparam level_t LEVEL_CONE  = 3'd2;
	localparam level_t LEVEL_HALF  = 3'd3;
	localparam level_t LEVEL_NONE  = 3'd4;
	localparam gap_t   GAP_NONE    = '1;

endpackage

// ----- design/spatial_focus_neighbor_select.sv -----
// ----------------------------------------------------------------------------
// spatial_focus_neighbor_select: nearest neighbour actions per direction
// Judges a stream of candidate rectangles against a configured origin and
// emits one replace / tie / no-change action per direction for each request.
// ----------------------------------------------------------------------------
// Usage:
//   Write the origin rectangle through cfg_en / cfg_index / cfg_data while no
//   request is in flight. Candidate requests enter on in_valid / in_ready;
//   each gives exactly one result on out_valid / out_ready, in order.
//   Set first on the opening candidate of a scan to clear the per-direction
//   bests; the consumer rebuilds its neighbour lists from the actions.
//   A request passes the input register, then the result register, before
//   out_valid rises. One request per cycle while the receiver takes results;
//   the judgement against the four best registers is combinational between
//   the input register and the result register.
//   A stalled receiver holds the result register; the input register still
//   takes one more request, then in_ready drops until the result is taken.
//   Reset clears the origin to zero, empties both registers and sets every
//   direction best to none found.
// ----------------------------------------------------------------------------
module spatial_focus_neighbor_select
	import sfns_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_en,
	input  logic [1:0]                cfg_index,
	input  logic [COORD_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      first,
	input  logic                      is_origin,
	input  logic [ID_W-1:0]           cand_id,
	input  logic signed [COORD_W-1:0] cand_x,
	input  logic signed [COORD_W-1:0] cand_y,
	input  logic [SIZE_W-1:0]         cand_w,
	input  logic [SIZE_W-1:0]         cand_h,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ID_W-1:0]           out_id,
	output logic [1:0]                top_action,
	output logic [1:0]                right_action,
	output logic [1:0]                left_action,
	output logic [1:0]                bottom_action
);

	logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [SIZE_W-1:0]         origin_w_q, origin_h_q;

	logic                      valid_s1;
	logic                      first_s1, is_origin_s1;
	logic [ID_W-1:0]           id_s1;
	logic signed [COORD_W-1:0] x_s1, y_s1;
	logic [SIZE_W-1:0]         w_s1, h_s1;

	level_t best_level_q [NUM_DIR];
	gap_t   best_gap_q   [NUM_DIR];
	level_t level_nxt    [NUM_DIR];
	gap_t   gap_nxt      [NUM_DIR];
	action_t act         [NUM_DIR];

	logic      out_valid_q;
	logic [ID_W-1:0] out_id_q;
	action_t   act_q [NUM_DIR];

	logic advance;

	calc_t ox, oy, ow, oh, ex, ey, ew, eh;
	calc_t ox_r, oy_b, ex_r, ey_b;
	calc_t dis_t, dis_b, dis_r, dis_l;
	logic  skip;
	logic  in3 [NUM_DIR];
	logic  in2 [NUM_DIR];
	logic  in1 [NUM_DIR];
	gap_t  gap [NUM_DIR];

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_w_q <= '0;
			origin_h_q <= '0;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_ORIGIN_W: origin_w_q <= cfg_data[SIZE_W-1:0];
				REG_ORIGIN_H: origin_h_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			first_s1     <= first;
			is_origin_s1 <= is_origin;
			id_s1        <= cand_id;
			x_s1         <= cand_x;
			y_s1         <= cand_y;
			w_s1         <= cand_w;
			h_s1         <= cand_h;
		end
	end

	always_comb begin
		ox = {{(CALC_W-COORD_W){origin_x_q[COORD_W-1]}}, origin_x_q};
		oy = {{(CALC_W-COORD_W){origin_y_q[COORD_W-1]}}, origin_y_q};
		ow = {{(CALC_W-SIZE_W){1'b0}}, origin_w_q};
		oh = {{(CALC_W-SIZE_W){1'b0}}, origin_h_q};
		ex = {{(CALC_W-COORD_W){x_s1[COORD_W-1]}}, x_s1};
		ey = {{(CALC_W-COORD_W){y_s1[COORD_W-1]}}, y_s1};
		ew = {{(CALC_W-SIZE_W){1'b0}}, w_s1};
		eh = {{(CALC_W-SIZE_W){1'b0}}, h_s1};

		ox_r = ox + ow;
		oy_b = oy + oh;
		ex_r = ex + ew;
		ey_b = ey + eh;

		skip = is_origin_s1 ||
			((ow != '0) && (ew != '0) && (ox < ex_r) && (ex < ox_r) &&
			 (oh != '0) && (eh != '0) && (oy < ey_b) && (ey < oy_b));

		dis_t = oy - ey;
		dis_b = ey_b - oy;
		dis_r = ex_r - ox;
		dis_l = ox - ex;

		in3[DIR_TOP]    = ey_b <= oy;
		in3[DIR_BOTTOM] = ey >= oy_b;
		in3[DIR_RIGHT]  = ex >= ox_r;
		in3[DIR_LEFT]   = ex_r <= ox;

		in1[DIR_TOP]    = !(ex_r <= ox || ex >= ox_r);
		in1[DIR_BOTTOM] = in1[DIR_TOP];
		in1[DIR_RIGHT]  = !(ey_b <= oy || ey >= oy_b);
		in1[DIR_LEFT]   = in1[DIR_RIGHT];

		in2[DIR_TOP]    = !(ex_r <= ox - dis_t || ex >= ox_r + dis_t);
		in2[DIR_BOTTOM] = !(ex_r <= ox - dis_b || ex >= ox_r + dis_b);
		in2[DIR_RIGHT]  = !(ey_b <= oy - dis_r || ey >= oy_b + dis_r);
		in2[DIR_LEFT]   = !(ey_b <= oy - dis_l || ey >= oy_b + dis_l);

		gap[DIR_TOP]    = gap_t'(oy - ey_b);
		gap[DIR_BOTTOM] = gap_t'(ey - oy_b);
		gap[DIR_RIGHT]  = gap_t'(ex - ox_r);
		gap[DIR_LEFT]   = gap_t'(ox - ex_r);
	end

	always_comb begin
		level_t cur_lvl;
		gap_t   cur_gap;
		level_t lvl;
		for (int d = 0; d < NUM_DIR; d++) begin
			cur_lvl = first_s1 ? LEVEL_NONE : best_level_q[d];
			cur_gap = first_s1 ? GAP_NONE : best_gap_q[d];
			lvl     = in1[d] ? LEVEL_SPAN : (in2[d] ? LEVEL_CONE : LEVEL_HALF);
			act[d]       = ACT_NONE;
			level_nxt[d] = cur_lvl;
			gap_nxt[d]   = cur_gap;
			if (!skip && in3[d]) begin
				if (lvl < cur_lvl) begin
					act[d]       = ACT_REPLACE;
					level_nxt[d] = lvl;
					gap_nxt[d]   = gap[d];
				end else if (lvl == cur_lvl && cur_gap > gap[d]) begin
					act[d]     = ACT_REPLACE;
					gap_nxt[d] = gap[d];
				end else if (lvl == cur_lvl && cur_gap == gap[d]) begin
					act[d] = ACT_TIE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIR; d++) begin
				best_level_q[d] <= LEVEL_NONE;
				best_gap_q[d]   <= GAP_NONE;
			end
		end else if (advance) begin
			for (int d = 0; d < NUM_DIR; d++) begin
				best_level_q[d] <= level_nxt[d];
				best_gap_q[d]   <= gap_nxt[d];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_id_q <= id_s1;
			for (int d = 0; d < NUM_DIR; d++) begin
				act_q[d] <= act[d];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_id        = out_id_q;
	assign top_action    = act_q[DIR_TOP];
	assign right_action  = act_q[DIR_RIGHT];
	assign left_action   = act_q[DIR_LEFT];
	assign bottom_action = act_q[DIR_BOTTOM];

`ifndef SYNTHESIS
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after advance");

	a_none_level_full_gap: assert property (@(posedge clk) disable iff (!arst_n)
		best_level_q[DIR_TOP] == LEVEL_NONE |-> best_gap_q[DIR_TOP] == GAP_NONE)
		else $error("top best empty but gap not cleared");

	a_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		best_level_q[DIR_BOTTOM] != 3'd0 && best_level_q[DIR_RIGHT] != 3'd0)
		else $error("best level zero");

	a_tie_keeps_best: assert property (@(posedge clk) disable iff (!arst_n)
		advance && act[DIR_LEFT] == ACT_TIE |=>
			$stable(best_level_q[DIR_LEFT]) && $stable(best_gap_q[DIR_LEFT]))
		else $error("tie altered left best");

	a_skip_no_action: assert property (@(posedge clk) disable iff (!arst_n)
		advance && skip |=> top_action == ACT_NONE && bottom_action == ACT_NONE)
		else $error("skipped candidate produced an action");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for spatial_focus_neighbor_select
// Streams candidate rectangles past a series of origin settings (reset origin,
// a hand-placed origin, zero-sized and extreme origins, random ones). A local
// model of the per-direction bests predicts the four actions of each request.
// Each result is compared, field by field, against the oldest prediction. Both
// handshakes idle at random, and the receiver holds off once long enough to
// stall the input.
// ----------------------------------------------------------------------------
module tb
	import sfns_pkg::*;
;

	localparam int ITEMS_PER_PHASE = 128;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int SETTLE_CYCLES   = 4;

	typedef struct packed {
		logic               first;
		logic               is_origin;
		logic [ID_W-1:0]    id;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SIZE_W-1:0]  w;
		logic [SIZE_W-1:0]  h;
	} cand_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		action_t         top;
		action_t         right;
		action_t         left;
		action_t         bottom;
	} verdict_t;

	class neighbour_scoreboard;
		int       org_x, org_y, org_w, org_h;
		level_t   best_lvl [NUM_DIR];
		gap_t     best_gap [NUM_DIR];
		verdict_t expected_actions [$];
		int       errors, noted, checked, skipped, replaces, ties;

		function new();
			clear_bests();
		endfunction

		function void clear_bests();
			for (int d = 0; d < NUM_DIR; d++) begin
				best_lvl[d] = LEVEL_NONE;
				best_gap[d] = GAP_NONE;
			end
		endfunction

		function void set_origin(reg_index_t idx, logic [COORD_W-1:0] val);
			case (idx)
			REG_ORIGIN_X: org_x = int'($signed(val));
			REG_ORIGIN_Y: org_y = int'($signed(val));
			REG_ORIGIN_W: org_w = int'(val[SIZE_W-1:0]);
			default:      org_h = int'(val[SIZE_W-1:0]);
			endcase
		endfunction

		function bit meets(int a, int la, int b, int lb);
			return !((b + lb) <= a || b >= (a + la));
		endfunction

		function bit overlaps(int a, int la, int b, int lb);
			int lo, hi;
			lo = (a > b) ? a : b;
			hi = ((a + la) < (b + lb)) ? (a + la) : (b + lb);
			return lo < hi;
		endfunction

		function action_t judge(logic [1:0] dir, bit beyond, bit cone, bit span,
				int gap_full);
			level_t lvl;
			gap_t   g;
			if (!beyond)
				return ACT_NONE;
			lvl = span ? LEVEL_SPAN : (cone ? LEVEL_CONE : LEVEL_HALF);
			g = gap_t'(gap_full);
			if (lvl < best_lvl[dir] || (lvl == best_lvl[dir] && best_gap[dir] > g)) begin
				best_lvl[dir] = lvl;
				best_gap[dir] = g;
				replaces++;
				return ACT_REPLACE;
			end
			if (lvl == best_lvl[dir] && best_gap[dir] == g) begin
				ties++;
				return ACT_TIE;
			end
			return ACT_NONE;
		endfunction

		function void note_candidate(cand_t c);
			int       ex, ey, ew, eh, reach;
			bit       up3, up2, up1, dn3, dn2, dn1, rt3, rt2, rt1, lt3, lt2, lt1;
			verdict_t v;
			ex = int'($signed(c.x));
			ey = int'($signed(c.y));
			ew = int'(c.w);
			eh = int'(c.h);
			{up2, up1, dn2, dn1, rt2, rt1, lt2, lt1} = '0;
			v.id     = c.id;
			v.top    = ACT_NONE;
			v.right  = ACT_NONE;
			v.left   = ACT_NONE;
			v.bottom = ACT_NONE;
			noted++;
			if (c.first)
				clear_bests();
			if (c.is_origin ||
					(overlaps(org_x, org_w, ex, ew) && overlaps(org_y, org_h, ey, eh))) begin
				skipped++;
			end else begin
				up3 = (ey + eh) <= org_y;
				dn3 = ey >= (org_y + org_h);
				rt3 = ex >= (org_x + org_w);
				lt3 = (ex + ew) <= org_x;
				if (up3) begin
					reach = org_y - ey;
					up2 = meets(org_x - reach, 2 * reach + org_w, ex, ew);
					up1 = meets(org_x, org_w, ex, ew);
				end
				if (dn3) begin
					reach = (ey + eh) - org_y;
					dn2 = meets(org_x - reach, 2 * reach + org_w, ex, ew);
					dn1 = meets(org_x, org_w, ex, ew);
				end
				if (rt3) begin
					reach = (ex + ew) - org_x;
					rt2 = meets(org_y - reach, 2 * reach + org_h, ey, eh);
					rt1 = meets(org_y, org_h, ey, eh);
				end
				if (lt3) begin
					reach = org_x - ex;
					lt2 = meets(org_y - reach, 2 * reach + org_h, ey, eh);
					lt1 = meets(org_y, org_h, ey, eh);
				end
				v.top    = judge(DIR_TOP, up3, up2, up1, org_y - (ey + eh));
				v.right  = judge(DIR_RIGHT, rt3, rt2, rt1, ex - (org_x + org_w));
				v.left   = judge(DIR_LEFT, lt3, lt2, lt1, org_x - (ex + ew));
				v.bottom = judge(DIR_BOTTOM, dn3, dn2, dn1, ey - (org_y + org_h));
			end
			expected_actions.push_back(v);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("%0t ns mismatch: %s", $time, what);
		endtask

		task compare_field(string name, logic [15:0] got, logic [15:0] want, logic [ID_W-1:0] id);
			if (got !== want)
				report($sformatf("candidate %0d %s is %0d, expected %0d", id, name, got, want));
		endtask

		task check_actions(logic [ID_W-1:0] id, logic [1:0] t, logic [1:0] r, logic [1:0] l,
				logic [1:0] b);
			verdict_t want;
			if (expected_actions.size() == 0) begin
				report($sformatf("result for candidate %0d with no request pending", id));
				return;
			end
			want = expected_actions.pop_front();
			checked++;
			compare_field("id", id, want.id, want.id);
			compare_field("top action", 16'(t), 16'(want.top), want.id);
			compare_field("right action", 16'(r), 16'(want.right), want.id);
			compare_field("left action", 16'(l), 16'(want.left), want.id);
			compare_field("bottom action", 16'(b), 16'(want.bottom), want.id);
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_en;
	logic [1:0]         cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               first;
	logic               is_origin;
	logic [ID_W-1:0]    cand_id;
	logic [COORD_W-1:0] cand_x;
	logic [COORD_W-1:0] cand_y;
	logic [SIZE_W-1:0]  cand_w;
	logic [SIZE_W-1:0]  cand_h;
	logic               out_valid;
	logic               out_ready;
	logic [ID_W-1:0]    out_id;
	logic [1:0]         top_action;
	logic [1:0]         right_action;
	logic [1:0]         left_action;
	logic [1:0]         bottom_action;

	bit calm;
	bit hold_off_req;
	int settings_used;

	neighbour_scoreboard sb = new();

	spatial_focus_neighbor_select dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding", sb.expected_actions.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_candidate({first, is_origin, cand_id, cand_x, cand_y, cand_w, cand_h});
		if (arst_n && out_valid && out_ready)
			sb.check_actions(out_id, top_action, right_action, left_action, bottom_action);
	end

	// result side: random stalls, with one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready = 1'b0;
				for (int n = 0; n < HOLD_OFF_CYCLES; n++)
					@(negedge clk);
			end
			if (calm)
				out_ready = 1'b1;
			else
				out_ready = ($urandom_range(99) >= 17);
		end
	end

	task automatic offer(cand_t c);
		if (!calm) begin
			while ($urandom_range(99) < 17) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		in_valid  = 1'b1;
		first     = c.first;
		is_origin = c.is_origin;
		cand_id   = c.id;
		cand_x    = c.x;
		cand_y    = c.y;
		cand_w    = c.w;
		cand_h    = c.h;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic place(bit f, bit o, int id, int x, int y, int w, int h);
		cand_t c;
		c.first     = f;
		c.is_origin = o;
		c.id        = 16'(id);
		c.x         = 16'(x);
		c.y         = 16'(y);
		c.w         = 15'(w);
		c.h         = 15'(h);
		offer(c);
	endtask

	// drain every pending request before touching the origin
	task automatic settle();
		in_valid = 1'b0;
		while (sb.expected_actions.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_origin(reg_index_t idx, logic [COORD_W-1:0] val);
		cfg_en    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		sb.set_origin(idx, val);
		@(negedge clk);
		cfg_en = 1'b0;
	endtask

	task automatic set_origin_rect(logic [15:0] x, logic [15:0] y, logic [15:0] w,
			logic [15:0] h);
		settle();
		write_origin(REG_ORIGIN_X, x);
		write_origin(REG_ORIGIN_Y, y);
		write_origin(REG_ORIGIN_W, w);
		write_origin(REG_ORIGIN_H, h);
		settings_used++;
	endtask

	function automatic int pick_size();
		case ($urandom_range(5))
		0: return 0;
		1: return 1;
		2: return 4;
		3: return 8;
		4: return 16;
		default: return int'($urandom_range(40));
		endcase
	endfunction

	// mostly rectangles on a coarse grid around the origin edges, so that levels
	// and gaps repeat and ties come up; the rest is noise over the full range
	function automatic cand_t random_candidate(bit opening);
		cand_t c;
		int    w, h, ax, ay, stride;
		c.first     = opening || ($urandom_range(99) < 3);
		c.is_origin = ($urandom_range(99) < 5);
		c.id        = 16'($urandom);
		if ($urandom_range(99) < 15) begin
			c.x = 16'($urandom);
			c.y = 16'($urandom);
			c.w = 15'($urandom);
			c.h = 15'($urandom);
			return c;
		end
		stride = ($urandom_range(9) == 0) ? 256 : 4;
		w = pick_size();
		h = pick_size();
		case ($urandom_range(2))
		0: ax = sb.org_x;
		1: ax = sb.org_x + sb.org_w;
		default: ax = sb.org_x - w;
		endcase
		case ($urandom_range(2))
		0: ay = sb.org_y;
		1: ay = sb.org_y + sb.org_h;
		default: ay = sb.org_y - h;
		endcase
		c.x = 16'(ax + stride * (int'($urandom_range(24)) - 12));
		c.y = 16'(ay + stride * (int'($urandom_range(24)) - 12));
		c.w = 15'(w);
		c.h = 15'(h);
		return c;
	endfunction

	task automatic run_scans(int count);
		int    left_in_scan;
		bit    opening;
		cand_t c;
		left_in_scan = 0;
		for (int i = 0; i < count; i++) begin
			opening = (left_in_scan == 0);
			if (opening)
				left_in_scan = int'($urandom_range(3, 24));
			c = random_candidate(opening);
			left_in_scan--;
			offer(c);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_en        = 1'b0;
		cfg_index     = REG_ORIGIN_X;
		cfg_data      = '0;
		in_valid      = 1'b0;
		first         = 1'b0;
		is_origin     = 1'b0;
		cand_id       = '0;
		cand_x        = '0;
		cand_y        = '0;
		cand_w        = '0;
		cand_h        = '0;
		calm          = 1'b0;
		hold_off_req  = 1'b0;
		settings_used = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// origin left at its reset value
		run_scans(ITEMS_PER_PHASE);

		set_origin_rect(16'd100, -16'sd50, 16'd20, 16'd10);
		place(1, 1, 16'h0000, 100, -50, 20, 10);
		place(0, 0, 1, 110, -45, 4, 2);
		place(0, 0, 2, 105, -70, 5, 10);
		place(0, 0, 3, 112, -65, 2, 5);
		place(0, 0, 4, 125, -80, 5, 5);
		place(0, 0, 5, -30000, -30000, 5, 5);
		place(0, 0, 6, 121, -48, 3, 3);
		place(0, 0, 7, 130, -30, 2, 2);
		place(0, 0, 8, 200, 100, 1, 1);
		place(0, 0, 9, 90, -45, 0, 0);
		place(0, 0, 10, 80, -48, 10, 2);
		place(0, 0, 11, 60, -100, 5, 5);
		place(0, 0, 12, 105, -38, 3, 4);
		place(0, 0, 13, 120, -50, 0, 10);
		place(0, 1, 14, 0, 0, 1, 1);
		place(0, 0, 16'hffff, -32768, -32768, 32767, 32767);
		place(0, 0, 16'h8000, 32767, 32767, 0, 0);
		place(1, 0, 15, 32767, -32768, 32767, 0);
		place(0, 0, 16, -32768, 32767, 0, 32767);

		// zero-sized origin: a point candidate sits in all four zones at once
		set_origin_rect(16'd100, -16'sd50, 16'd0, 16'd0);
		place(1, 0, 17, 100, -50, 0, 0);
		place(0, 0, 18, 100, -60, 0, 5);
		place(0, 0, 19, 100, -50, 0, 0);

		for (int p = 0; p < 8; p++) begin
			case (p)
			0: set_origin_rect(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
			1: set_origin_rect(16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
			2: set_origin_rect(16'h8000, 16'h7fff, 16'h8000, 16'hffff);
			3: set_origin_rect(16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
			default: set_origin_rect(16'($urandom), 16'($urandom),
					{1'($urandom), 15'($urandom_range(48))},
					{1'($urandom), 15'($urandom_range(48))});
			endcase
			calm = (p == 2) || (p == 4);
			if (p == 4)
				hold_off_req = 1'b1;
			run_scans(ITEMS_PER_PHASE);
		end
		calm = 1'b0;

		settle();
		$display("Judged %0d candidates under %0d origin settings:", sb.noted,
				settings_used);
		$display("%0d results checked, %0d skipped, %0d replace and %0d tie actions predicted.",
				sb.checked, sb.skipped, sb.replaces, sb.ties);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- spatial_focus_neighbor_select.f -----
design/sfns_pkg.sv
design/spatial_focus_neighbor_select.sv
test/tb.sv
